[rtl/core/ddhc_pkg.sv]
// ----------------------------------------------------------------------------
// ddhc_pkg
// Shared constants, types and the arctangent table of the heading command
// pipeline.
// ----------------------------------------------------------------------------
package ddhc_pkg;

  localparam int unsigned CORDIC_ITER_DEF = 16;
  localparam int unsigned CORDIC_ITER_MAX = 24;
  localparam int unsigned SQRT_STEPS      = 16;

  // angles are Q30 radians
  typedef logic signed [34:0] ang_t;

  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam ang_t               PI_A        = 35'sd3373259426;
  localparam ang_t               HALF_PI_A   = 35'sd1686629713;
  localparam logic signed [32:0] INV_GAIN_Q30 = 33'sd652032874;
  localparam logic signed [16:0] TOL_Q13      = 17'sd1638;
  localparam logic signed [16:0] GAIN_03_Q16  = 17'sd19661;

  typedef enum logic {
    REG_MAX_LINEAR  = 1'b0,
    REG_MAX_ANGULAR = 1'b1
  } reg_idx_e;

  // word leaving the vectoring section
  typedef struct packed {
    logic               valid;
    logic [15:0]        speed;
    ang_t               ang;
    logic signed [15:0] heading;
  } vec_t;

  // word leaving the rotation section
  typedef struct packed {
    logic               valid;
    logic               turn;
    logic               neg;
    logic [15:0]        speed;
    logic signed [16:0] ang_cmd;
    logic signed [32:0] cos_x;
  } rot_t;

  function automatic ang_t atan_q30(input int unsigned i);
    ang_t r;
    case (i)
      0:  r = 35'sd843314857;
      1:  r = 35'sd497837829;
      2:  r = 35'sd263043837;
      3:  r = 35'sd133525159;
      4:  r = 35'sd67021687;
      5:  r = 35'sd33543516;
      6:  r = 35'sd16775851;
      7:  r = 35'sd8388437;
      8:  r = 35'sd4194283;
      9:  r = 35'sd2097149;
      10: r = 35'sd1048576;
      11: r = 35'sd524288;
      12: r = 35'sd262144;
      13: r = 35'sd131072;
      14: r = 35'sd65536;
      15: r = 35'sd32768;
      16: r = 35'sd16384;
      17: r = 35'sd8192;
      18: r = 35'sd4096;
      19: r = 35'sd2048;
      20: r = 35'sd1024;
      21: r = 35'sd512;
      22: r = 35'sd256;
      23: r = 35'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/ddhc_vec_pipe.sv]
// ----------------------------------------------------------------------------
// ddhc_vec_pipe
// Vectoring CORDIC for atan2 and a digit-per-stage square root for speed,
// running side by side, one stage per iteration.
// ----------------------------------------------------------------------------
module ddhc_vec_pipe
  import ddhc_pkg::*;
#(
  parameter int unsigned CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [15:0] x_i,
  input  logic signed [15:0] y_i,
  input  logic signed [15:0] hd_i,
  output vec_t               out_o
);

  localparam int unsigned NI = (CORDIC_ITERATIONS > CORDIC_ITER_MAX) ?
                               CORDIC_ITER_MAX : CORDIC_ITERATIONS;
  localparam int unsigned LA = (NI > SQRT_STEPS) ? NI : SQRT_STEPS;

  logic               v0_q;
  logic signed [15:0] vx0_q, vy0_q, hd0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vx0_q <= x_i;
      vy0_q <= y_i;
      hd0_q <= hd_i;
    end
  end

  logic               v_q   [LA+1];
  logic signed [33:0] x_q   [LA+1];
  logic signed [33:0] y_q   [LA+1];
  ang_t               z_q   [LA+1];
  logic [31:0]        rem_q [LA+1];
  logic [31:0]        res_q [LA+1];
  logic signed [15:0] hd_q  [LA+1];
  logic               zr_q  [LA+1];

  // squares and half-plane pre-rotation
  logic signed [31:0] sqx, sqy;
  logic [31:0]        sqsum;
  logic signed [33:0] xe, ye, x1, y1;
  ang_t               z1;

  always_comb begin
    sqx   = vx0_q * vx0_q;
    sqy   = vy0_q * vy0_q;
    sqsum = 32'(sqx) + 32'(sqy);
    xe    = 34'(vx0_q) <<< 14;
    ye    = 34'(vy0_q) <<< 14;
    if (vx0_q < 0) begin
      x1 = -xe;
      y1 = -ye;
      z1 = (vy0_q >= 0) ? PI_A : -PI_A;
    end else begin
      x1 = xe;
      y1 = ye;
      z1 = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= x1;
      y_q[0]   <= y1;
      z_q[0]   <= z1;
      rem_q[0] <= sqsum;
      res_q[0] <= '0;
      hd_q[0]  <= hd0_q;
      zr_q[0]  <= (vx0_q == 0) && (vy0_q == 0);
    end
  end

  for (genvar k = 0; k < LA; k++) begin : g_stage
    logic signed [33:0] xn, yn;
    ang_t               zn;
    logic [31:0]        remn, resn;

    always_comb begin
      xn = x_q[k];
      yn = y_q[k];
      zn = z_q[k];
      if (k < NI) begin
        if (y_q[k] >= 0) begin
          xn = x_q[k] + (y_q[k] >>> k);
          yn = y_q[k] - (x_q[k] >>> k);
          zn = z_q[k] + atan_q30(k);
        end else begin
          xn = x_q[k] - (y_q[k] >>> k);
          yn = y_q[k] + (x_q[k] >>> k);
          zn = z_q[k] - atan_q30(k);
        end
      end
    end

    if (k < SQRT_STEPS) begin : g_sqrt
      localparam logic [31:0] BIT = 32'(1) << (30 - 2 * k);
      logic [32:0] trial;
      always_comb begin
        trial = 33'(res_q[k]) + 33'(BIT);
        if (33'(rem_q[k]) >= trial) begin
          remn = rem_q[k] - trial[31:0];
          resn = (res_q[k] >> 1) + BIT;
        end else begin
          remn = rem_q[k];
          resn = res_q[k] >> 1;
        end
      end
    end else begin : g_pass
      always_comb begin
        remn = rem_q[k];
        resn = res_q[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k+1]   <= xn;
        y_q[k+1]   <= yn;
        z_q[k+1]   <= zn;
        rem_q[k+1] <= remn;
        res_q[k+1] <= resn;
        hd_q[k+1]  <= hd_q[k];
        zr_q[k+1]  <= zr_q[k];
      end
    end
  end

  // zero vector has angle zero
  always_comb begin
    out_o.valid   = v_q[LA];
    out_o.speed   = res_q[LA][15:0];
    out_o.ang     = zr_q[LA] ? '0 : z_q[LA];
    out_o.heading = hd_q[LA];
  end

endmodule

[rtl/core/ddhc_rot_pipe.sv]
// ----------------------------------------------------------------------------
// ddhc_rot_pipe
// Heading error, wrap into +-pi, mode select and a rotation CORDIC for
// cos(err), one stage per iteration.
// ----------------------------------------------------------------------------
module ddhc_rot_pipe
  import ddhc_pkg::*;
#(
  parameter int unsigned CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  vec_t in_i,
  output rot_t out_o
);

  localparam int unsigned NI = (CORDIC_ITERATIONS > CORDIC_ITER_MAX) ?
                               CORDIC_ITER_MAX : CORDIC_ITERATIONS;

  logic               v0_q, v1_q;
  logic signed [35:0] err0_q;
  ang_t               err1_q;
  logic [15:0]        sp0_q, sp1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= in_i.valid;
      v1_q <= v0_q;
    end
  end

  logic signed [35:0] wrapped;

  always_comb begin
    if (err0_q > PI_Q30) begin
      wrapped = err0_q - TWO_PI_Q30;
    end else if (err0_q < -PI_Q30) begin
      wrapped = err0_q + TWO_PI_Q30;
    end else begin
      wrapped = err0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      err0_q <= 36'(in_i.ang) - (36'(in_i.heading) <<< 17);
      sp0_q  <= in_i.speed;
      err1_q <= 35'(wrapped);
      sp1_q  <= sp0_q;
    end
  end

  // mode, angular command and quadrant fold for the cosine
  ang_t               r13, r18, zc;
  logic signed [16:0] e13, e18;
  logic               turn, neg;

  always_comb begin
    r13  = err1_q + 35'sd65536;
    r18  = err1_q + 35'sd131072;
    e13  = 17'(r13 >>> 17);
    e18  = 17'(r18 >>> 18);
    turn = (e13 > TOL_Q13) || (e13 < -TOL_Q13);
    if (err1_q > HALF_PI_A) begin
      zc  = err1_q - PI_A;
      neg = 1'b1;
    end else if (err1_q < -HALF_PI_A) begin
      zc  = err1_q + PI_A;
      neg = 1'b1;
    end else begin
      zc  = err1_q;
      neg = 1'b0;
    end
  end

  logic               v_q  [NI+1];
  logic signed [32:0] x_q  [NI+1];
  logic signed [32:0] y_q  [NI+1];
  ang_t               z_q  [NI+1];
  logic               t_q  [NI+1];
  logic               n_q  [NI+1];
  logic signed [16:0] a_q  [NI+1];
  logic [15:0]        s_q  [NI+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= INV_GAIN_Q30;
      y_q[0] <= '0;
      z_q[0] <= zc;
      t_q[0] <= turn;
      n_q[0] <= neg;
      a_q[0] <= turn ? e13 : e18;
      s_q[0] <= sp1_q;
    end
  end

  for (genvar k = 0; k < NI; k++) begin : g_stage
    logic signed [32:0] xn, yn;
    ang_t               zn;

    always_comb begin
      if (z_q[k] >= 0) begin
        xn = x_q[k] - (y_q[k] >>> k);
        yn = y_q[k] + (x_q[k] >>> k);
        zn = z_q[k] - atan_q30(k);
      end else begin
        xn = x_q[k] + (y_q[k] >>> k);
        yn = y_q[k] - (x_q[k] >>> k);
        zn = z_q[k] + atan_q30(k);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k+1] <= xn;
        y_q[k+1] <= yn;
        z_q[k+1] <= zn;
        t_q[k+1] <= t_q[k];
        n_q[k+1] <= n_q[k];
        a_q[k+1] <= a_q[k];
        s_q[k+1] <= s_q[k];
      end
    end
  end

  always_comb begin
    out_o.valid   = v_q[NI];
    out_o.turn    = t_q[NI];
    out_o.neg     = n_q[NI];
    out_o.speed   = s_q[NI];
    out_o.ang_cmd = a_q[NI];
    out_o.cos_x   = x_q[NI];
  end

endmodule

[rtl/core/ddhc_out_pipe.sv]
// ----------------------------------------------------------------------------
// ddhc_out_pipe
// Speed times cosine, turn-mode gain and symmetric clamp; the last stage is
// the output register.
// ----------------------------------------------------------------------------
module ddhc_out_pipe
  import ddhc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  rot_t               in_i,
  input  logic [14:0]        max_lin_i,
  input  logic [14:0]        max_ang_i,
  output logic               valid_o,
  output logic signed [15:0] lin_o,
  output logic signed [15:0] ang_o,
  output logic               turn_o
);

  logic               v0_q, v1_q, v2_q, v3_q;
  logic               t0_q, t1_q, t2_q;
  logic signed [16:0] a0_q, a1_q, a2_q;
  logic [15:0]        s0_q;
  logic signed [32:0] c0_q;
  logic signed [17:0] l1_q, l2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= in_i.valid;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  logic signed [49:0] prod;
  logic signed [49:0] prod_r;
  logic signed [35:0] gprod;
  logic signed [35:0] gprod_r;
  logic signed [17:0] lin_g;
  logic signed [17:0] lim_l;
  logic signed [16:0] lim_a;
  logic signed [17:0] lin_c;
  logic signed [16:0] ang_c;

  always_comb begin
    prod    = 50'(signed'({1'b0, s0_q})) * 50'(c0_q);
    prod_r  = prod + 50'sd536870912;
    gprod   = 36'(l1_q) * 36'(GAIN_03_Q16);
    gprod_r = gprod + 36'sd32768;
    lin_g   = t1_q ? 18'(gprod_r >>> 16) : l1_q;
    lim_l   = signed'({3'b000, max_lin_i});
    lim_a   = signed'({2'b00, max_ang_i});
    if (l2_q > lim_l) begin
      lin_c = lim_l;
    end else if (l2_q < -lim_l) begin
      lin_c = -lim_l;
    end else begin
      lin_c = l2_q;
    end
    if (a2_q > lim_a) begin
      ang_c = lim_a;
    end else if (a2_q < -lim_a) begin
      ang_c = -lim_a;
    end else begin
      ang_c = a2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // fold sign back in before the multiply so rounding sees it
      c0_q   <= in_i.neg ? -in_i.cos_x : in_i.cos_x;
      s0_q   <= in_i.speed;
      t0_q   <= in_i.turn;
      a0_q   <= in_i.ang_cmd;
      l1_q   <= 18'(prod_r >>> 30);
      t1_q   <= t0_q;
      a1_q   <= a0_q;
      l2_q   <= lin_g;
      t2_q   <= t1_q;
      a2_q   <= a1_q;
      lin_o  <= 16'(lin_c);
      ang_o  <= 16'(ang_c);
      turn_o <= t2_q;
    end
  end

  assign valid_o = v3_q;

endmodule

[rtl/core/diff_drive_heading_command.sv]
// ----------------------------------------------------------------------------
// diff_drive_heading_command
// Velocity vector plus heading to clamped linear and angular drive commands.
// ----------------------------------------------------------------------------
// Fully pipelined: one word in and one word out per cycle when the consumer
// keeps ready high. The pipeline runs through the vectoring CORDIC and
// square-root stages, the rotation CORDIC stages and the multiply and
// clamp stages. All stages advance together; a held output word stalls the
// whole pipeline, and in_ready_o drops only then. Limits are sampled in the
// final clamp stage.
module diff_drive_heading_command
  import ddhc_pkg::*;
#(
  parameter int unsigned CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] desired_x_velocity_i,
  input  logic signed [15:0] desired_y_velocity_i,
  input  logic signed [15:0] heading_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] linear_command_o,
  output logic signed [15:0] angular_command_o,
  output logic               turn_priority_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [14:0]        cfg_data_i
);

  logic        en;
  logic [14:0] max_lin_q, max_ang_q;
  vec_t        vec;
  rot_t        rot;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_lin_q <= 15'd4096;
      max_ang_q <= 15'd8192;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_MAX_LINEAR:  max_lin_q <= cfg_data_i;
        REG_MAX_ANGULAR: max_ang_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ddhc_vec_pipe #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_vec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .x_i     (desired_x_velocity_i),
    .y_i     (desired_y_velocity_i),
    .hd_i    (heading_i),
    .out_o   (vec)
  );

  ddhc_rot_pipe #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_rot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .in_i   (vec),
    .out_o  (rot)
  );

  ddhc_out_pipe u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .in_i      (rot),
    .max_lin_i (max_lin_q),
    .max_ang_i (max_ang_q),
    .valid_o   (out_valid_o),
    .lin_o     (linear_command_o),
    .ang_o     (angular_command_o),
    .turn_o    (turn_priority_o)
  );

endmodule

[rtl/core/ddhc_checker.sv]
// ----------------------------------------------------------------------------
// ddhc_checker
// Port-level checks for the heading command block, bound to the top level.
// ----------------------------------------------------------------------------
module ddhc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] linear_command_o,
  input logic signed [15:0] angular_command_o,
  input logic               turn_priority_o
);

  // held word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(linear_command_o)
      && $stable(angular_command_o) && $stable(turn_priority_o))
    else $error("output word changed while stalled");

  // pipeline takes input exactly when it can move
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output side");

  // normal mode: |err| <= 0.2 rad, so the rate stays small
  a_norm_ang: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !turn_priority_o |->
      (angular_command_o <= 16'sd820) && (angular_command_o >= -16'sd820))
    else $error("angular command too large outside turn mode");

  // clamped commands never reach the most negative code
  a_no_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (linear_command_o != -16'sd32768)
      && (angular_command_o != -16'sd32768))
    else $error("command outside clamp range");

endmodule

bind diff_drive_heading_command ddhc_checker u_ddhc_checker (.*);

[test/diff_drive_heading_command_tb.sv]
// ----------------------------------------------------------------------------
// diff_drive_heading_command_tb
// Drives velocity vectors and headings through the heading command pipeline,
// predicts each drive command in fixed point and compares it on the output
// handshake. Covers limit settings from zero to full scale, random idling on
// both sides and a long consumer hold that backs the pipeline up.
// ----------------------------------------------------------------------------
module diff_drive_heading_command_tb
  import ddhc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_ITER   = 16;
  localparam int unsigned SETTLE   = 60;
  localparam int unsigned RAND_PER = 72;
  localparam longint      PI_V     = 64'sd3373259426;
  localparam longint      TWO_PI_V = 64'sd6746518852;
  localparam longint      HALF_PI  = 64'sd1686629713;
  localparam longint      K_INV    = 64'sd652032874;

  localparam longint ATAN_Q30 [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128
  };

  typedef struct {
    logic signed [15:0] lin;
    logic signed [15:0] ang;
    logic               turn;
  } drive_cmd_t;

  typedef struct {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] hd;
    bit                 typed;
    drive_cmd_t         cmd;
  } vec_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] desired_x_velocity_i = '0;
  logic signed [15:0] desired_y_velocity_i = '0;
  logic signed [15:0] heading_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] linear_command_o;
  logic signed [15:0] angular_command_o;
  logic               turn_priority_o;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = 1'b0;
  logic [14:0]        cfg_data_i = '0;

  logic [14:0] lim_linear  = 15'd4096;
  logic [14:0] lim_angular = 15'd8192;
  drive_cmd_t  pending_cmds[$];
  int          mismatches = 0;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;

  diff_drive_heading_command u_dut (.*);

  always #4 clk_i = ~clk_i;

  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic longint rshift_rnd(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint vec_magnitude(longint v);
    longint res, b;
    res = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - res - b;
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  function automatic longint bearing_q30(longint vx, longint vy);
    longint x, y, z, dx, dy;
    x = vx * 16384;
    y = vy * 16384;
    z = 0;
    if (vx == 0 && vy == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_V : -PI_V;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < N_ITER; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_Q30[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_Q30[i];
      end
    end
    return z;
  endfunction

  function automatic longint cosine_q30(longint z);
    longint x, y, dx, dy;
    bit flip;
    x = K_INV;
    y = 0;
    flip = 1'b0;
    if (z > HALF_PI) begin
      z -= PI_V; flip = 1'b1;
    end else if (z < -HALF_PI) begin
      z += PI_V; flip = 1'b1;
    end
    for (int i = 0; i < N_ITER; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_Q30[i];
      end else begin
        x += dx; y -= dy; z += ATAN_Q30[i];
      end
    end
    return flip ? -x : x;
  endfunction

  function automatic drive_cmd_t predict_drive_cmd(logic signed [15:0] vx,
                                                   logic signed [15:0] vy,
                                                   logic signed [15:0] hd);
    drive_cmd_t r;
    longint spd, err, e13, lin, ang, llim, alim;
    bit turn;
    spd = vec_magnitude(longint'(vx) * vx + longint'(vy) * vy);
    err = bearing_q30(vx, vy) - longint'(hd) * 131072;
    while (err > PI_V) err -= TWO_PI_V;
    while (err < -PI_V) err += TWO_PI_V;
    e13  = rshift_rnd(err, 17);
    turn = (e13 > 1638) || (e13 < -1638);
    lin  = rshift_rnd(spd * cosine_q30(err), 30);
    if (turn) begin
      lin = rshift_rnd(lin * 19661, 16);
      ang = rshift_rnd(err, 17);
    end else begin
      ang = rshift_rnd(err, 18);
    end
    llim = lim_linear;
    alim = lim_angular;
    if (lin > llim) lin = llim;
    if (lin < -llim) lin = -llim;
    if (ang > alim) ang = alim;
    if (ang < -alim) ang = -alim;
    r.lin  = lin[15:0];
    r.ang  = ang[15:0];
    r.turn = turn;
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t: %s mismatch: got %0d, want %0d", $time, field, got, want);
    mismatches++;
  endtask

  // compare every accepted result word against the oldest expectation
  always @(posedge clk_i) begin
    drive_cmd_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t: result word with nothing expected", $time);
        mismatches++;
      end else begin
        want = pending_cmds.pop_front();
        if (linear_command_o !== want.lin)
          report_mismatch("linear_command", linear_command_o, want.lin);
        if (angular_command_o !== want.ang)
          report_mismatch("angular_command", angular_command_o, want.ang);
        if (turn_priority_o !== want.turn)
          report_mismatch("turn_priority", turn_priority_o, want.turn);
      end
    end
  end

  // consumer: random stalls, plus one long hold on request
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req && hold == 0) hold = 300;
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= no_idle || ($urandom_range(99) >= 17);
      end
    end
  end

  task automatic send_vec(vec_row_t row);
    drive_cmd_t want;
    @(negedge clk_i);
    if (!no_idle) begin
      while ($urandom_range(99) < 17) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i           <= 1'b1;
    desired_x_velocity_i <= row.vx;
    desired_y_velocity_i <= row.vy;
    heading_i            <= row.hd;
    do @(posedge clk_i); while (!in_ready_o);
    want = row.typed ? row.cmd : predict_drive_cmd(row.vx, row.vy, row.hd);
    pending_cmds.push_back(want);
  endtask

  task automatic drain_pipe();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [14:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MAX_LINEAR) lim_linear = val;
    else lim_angular = val;
  endtask

  function automatic vec_row_t rand_row();
    vec_row_t r;
    r.typed = 1'b0;
    r.cmd   = '{default: '0};
    if ($urandom_range(9) < 2) begin
      r.vx = $signed(16'($urandom_range(8000))) - 16'sd4000;
      r.vy = $signed(16'($urandom_range(8000))) - 16'sd4000;
    end else begin
      r.vx = 16'($urandom);
      r.vy = 16'($urandom);
    end
    // mostly a proper heading, now and then anything the port allows
    if ($urandom_range(9) == 0) r.hd = 16'($urandom);
    else r.hd = $signed(16'($urandom_range(51472))) - 16'sd25736;
    return r;
  endfunction

  vec_row_t directed_rows[] = '{
    '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 16'sd0, 1'b0}},
    '{16'sd32767, 16'sd0, 16'sd0, 1'b0, '{default: '0}},
    '{-16'sd32768, 16'sd0, 16'sd0, 1'b0, '{default: '0}},
    '{-16'sd32768, -16'sd1, 16'sd0, 1'b0, '{default: '0}},
    '{16'sd0, 16'sd32767, 16'sd0, 1'b0, '{default: '0}},
    '{16'sd0, -16'sd32768, 16'sd0, 1'b0, '{default: '0}},
    '{16'sd32767, 16'sd32767, 16'sd0, 1'b0, '{default: '0}},
    '{-16'sd32768, -16'sd32768, 16'sd0, 1'b0, '{default: '0}},
    '{-16'sd32768, 16'sd32767, 16'sd25736, 1'b0, '{default: '0}},
    '{16'sd4096, 16'sd0, 16'sd25736, 1'b0, '{default: '0}},
    '{16'sd4096, 16'sd0, -16'sd25736, 1'b0, '{default: '0}},
    '{16'sd4096, 16'sd100, 16'sd32767, 1'b0, '{default: '0}},
    '{16'sd4096, -16'sd100, -16'sd32768, 1'b0, '{default: '0}},
    '{16'sd0, 16'sd0, 16'sd25736, 1'b0, '{default: '0}},
    '{16'sd0, 16'sd0, -16'sd32768, 1'b0, '{default: '0}},
    '{16'sd4096, 16'sd0, 16'sd1000, 1'b0, '{default: '0}},
    '{16'sd4096, 16'sd0, 16'sd1638, 1'b0, '{default: '0}},
    '{16'sd4096, 16'sd0, 16'sd1639, 1'b0, '{default: '0}},
    '{16'sd4096, 16'sd0, -16'sd1639, 1'b0, '{default: '0}},
    '{16'sd1, 16'sd0, 16'sd0, 1'b0, '{default: '0}},
    '{-16'sd1, 16'sd1, 16'sd0, 1'b0, '{default: '0}}
  };

  // limit settings per random phase (the last phase writes random limits instead): linear, angular
  logic [14:0] phase_lims[6][2] = '{
    '{15'd32767, 15'd32767}, '{15'd0, 15'd0}, '{15'd1, 15'd1},
    '{15'd4096, 15'd8192}, '{15'd0, 15'd32767}, '{15'd20000, 15'd3000}
  };

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) send_vec(directed_rows[i]);
    drain_pipe();

    for (int p = 0; p < 6; p++) begin
      if (p == 5) begin
        write_reg(REG_MAX_LINEAR, 15'($urandom));
        write_reg(REG_MAX_ANGULAR, 15'($urandom));
      end else begin
        write_reg(REG_MAX_LINEAR, phase_lims[p][0]);
        write_reg(REG_MAX_ANGULAR, phase_lims[p][1]);
      end
      no_idle = (p == 3);
      for (int k = 0; k < RAND_PER; k++) begin
        // back up the pipeline once while words keep arriving
        if (p == 1 && k == 5) hold_req = 1'b1;
        if (p == 1 && k == 10) hold_req = 1'b0;
        send_vec(rand_row());
      end
      drain_pipe();
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/ddhc_pkg.sv
rtl/core/ddhc_vec_pipe.sv
rtl/core/ddhc_rot_pipe.sv
rtl/core/ddhc_out_pipe.sv
rtl/core/diff_drive_heading_command.sv
rtl/core/ddhc_checker.sv
test/diff_drive_heading_command_tb.sv
